[rtl/cc20_pkg.sv]
// Shared types, constants and the quarter-round function for the ChaCha20 block unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package cc20_pkg;

  localparam int DOUBLE_ROUNDS = 10;
  localparam int NUM_ROUNDS    = 2 * DOUBLE_ROUNDS;
  localparam int RND_W         = (NUM_ROUNDS > 1) ? $clog2(NUM_ROUNDS) : 1;

  localparam int WORD_W   = 32;
  localparam int CFG_W    = 64;
  localparam int CFG_IDX_W = 3;
  localparam int OUT_W    = 16 * WORD_W;

  typedef logic [WORD_W-1:0]       cc20_word_t;
  typedef logic [15:0][WORD_W-1:0] cc20_state_t;
  typedef logic [3:0][WORD_W-1:0]  cc20_quad_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY0   = 3'd0,
    REG_KEY1   = 3'd1,
    REG_KEY2   = 3'd2,
    REG_KEY3   = 3'd3,
    REG_NONCE0 = 3'd4,
    REG_NONCE1 = 3'd5
  } cc20_reg_t;

  // "expand 32-byte k" as four little-endian words.
  localparam cc20_word_t SIGMA0 = 32'h6170_7865;
  localparam cc20_word_t SIGMA1 = 32'h3320_646e;
  localparam cc20_word_t SIGMA2 = 32'h7962_2d32;
  localparam cc20_word_t SIGMA3 = 32'h6b20_6574;

  // Element 0 is a, 1 is b, 2 is c, 3 is d.
  function automatic cc20_quad_t cc20_qr(input cc20_quad_t q);
    cc20_word_t a;
    cc20_word_t b;
    cc20_word_t c;
    cc20_word_t d;
    cc20_quad_t r;
    a = q[0];
    b = q[1];
    c = q[2];
    d = q[3];
    a = a + b;  d = d ^ a;  d = {d[15:0], d[31:16]};
    c = c + d;  b = b ^ c;  b = {b[19:0], b[31:20]};
    a = a + b;  d = d ^ a;  d = {d[23:0], d[31:24]};
    c = c + d;  b = b ^ c;  b = {b[24:0], b[31:25]};
    r[0] = a;
    r[1] = b;
    r[2] = c;
    r[3] = d;
    return r;
  endfunction

endpackage

[rtl/cc20_round.sv]
// One ChaCha20 round: four quarter-rounds side by side, column or diagonal.
// Depends on cc20_pkg for the state type and the quarter-round function.
`timescale 1ns / 1ps

module cc20_round (
  input  logic                 diag,
  input  cc20_pkg::cc20_state_t st_i,
  output cc20_pkg::cc20_state_t st_o
);
  import cc20_pkg::*;

  cc20_state_t shuf;
  cc20_state_t mixed;

  // A diagonal round is a column round on rows rotated left by their row number.
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int i = 0; i < 4; i++) begin
        shuf[4*r + i] = diag ? st_i[4*r + ((i + r) & 3)] : st_i[4*r + i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      cc20_quad_t q;
      cc20_quad_t res;
      q[0] = shuf[i];
      q[1] = shuf[4 + i];
      q[2] = shuf[8 + i];
      q[3] = shuf[12 + i];
      res = cc20_qr(q);
      mixed[i]      = res[0];
      mixed[4 + i]  = res[1];
      mixed[8 + i]  = res[2];
      mixed[12 + i] = res[3];
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int i = 0; i < 4; i++) begin
        st_o[4*r + i] = diag ? mixed[4*r + ((i + 4 - r) & 3)] : mixed[4*r + i];
      end
    end
  end

endmodule

[rtl/cc20_core.sv]
// Round sequencer: holds the working state, runs the shared round unit,
// adds the input state, keeps the block counter and the output register.
// Depends on cc20_pkg and cc20_round.
`timescale 1ns / 1ps

module cc20_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cc20_pkg::cc20_state_t      init_base,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [cc20_pkg::WORD_W-1:0] in_tdata,
  input  logic                       in_tuser,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [cc20_pkg::OUT_W-1:0] out_tdata,
  output logic                       out_tuser
);
  import cc20_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ROUND = 3'b010,
    ST_FINAL = 3'b100
  } cc20_st_t;

  cc20_st_t          state_r, state_nxt;
  logic [RND_W-1:0]  rnd_r, rnd_nxt;
  cc20_word_t        counter_r, counter_nxt;
  cc20_state_t       work_r;
  cc20_state_t       round_out;
  cc20_state_t       init_now;
  cc20_state_t       init_start;
  logic              out_tvalid_r, out_tvalid_nxt;
  logic [OUT_W-1:0]  out_tdata_r;
  logic              out_tuser_r;
  logic              accept;
  logic              fire;
  logic              last_round;

  cc20_round u_round (
    .diag (rnd_r[0]),
    .st_i (work_r),
    .st_o (round_out)
  );

  assign accept     = in_tvalid && in_tready;
  assign in_tready  = (state_r == ST_IDLE);
  assign last_round = (rnd_r == RND_W'(NUM_ROUNDS - 1));
  // The finished block moves out once the output register is free or being emptied.
  assign fire       = (state_r == ST_FINAL) && (!out_tvalid_r || out_tready);

  always_comb begin
    init_now     = init_base;
    init_now[12] = counter_r;
    init_start     = init_base;
    init_start[12] = in_tuser ? in_tdata : counter_r;
  end

  always_comb begin
    state_nxt      = state_r;
    rnd_nxt        = rnd_r;
    counter_nxt    = counter_r;
    out_tvalid_nxt = out_tvalid_r;
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        rnd_nxt = '0;
        if (accept) begin
          if (in_tuser) begin
            counter_nxt = in_tdata;
          end
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        rnd_nxt = rnd_r + 1'b1;
        if (last_round) begin
          state_nxt = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (fire) begin
          counter_nxt    = counter_r + 1'b1;
          out_tvalid_nxt = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      rnd_r        <= '0;
      counter_r    <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rnd_r        <= rnd_nxt;
      counter_r    <= counter_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      work_r <= init_start;
    end else if (state_r == ST_ROUND) begin
      work_r <= round_out;
    end
    if (fire) begin
      for (int k = 0; k < 16; k++) begin
        out_tdata_r[WORD_W*k +: WORD_W] <= work_r[k] + init_now[k];
      end
      out_tuser_r <= &counter_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  a_start_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_ROUND) && (rnd_r == '0))
    else $error("accepted item did not start the round sequence");

  a_rnd_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND) |-> (rnd_r <= RND_W'(NUM_ROUNDS - 1)))
    else $error("round count ran past the last round");

  a_fire_counter: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_tvalid_r && (counter_r == $past(counter_r) + 32'd1)
             && (out_tuser_r == (counter_r == '0)))
    else $error("block counter or wrap flag wrong after a finished block");

  a_final_after_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND) && last_round |=> (state_r == ST_FINAL))
    else $error("last round did not lead to the final add");

endmodule

[rtl/chacha20_keystream_block_unit.sv]
// ChaCha20 keystream block unit: top level with the key and nonce registers.
// Depends on cc20_pkg and cc20_core (which uses cc20_round).
//
// Usage:
//   The key and nonce are written through the cfg_ port (index 0..3 key
//   parts, 4 and 5 nonce parts, little-endian byte packing) while the unit
//   is idle; unknown indexes are ignored. Each input item requests one
//   64-byte keystream block. in_tuser set loads the 32-bit block counter
//   from in_tdata first; otherwise the running counter is used.
//   One result item per request: out_tdata carries keystream words 0..15,
//   word k at bits 32k+31..32k; out_tuser flags that the counter wrapped
//   to zero after this block.
//   Sequence: the accepting edge loads the state, then the 2*DOUBLE_ROUNDS
//   rounds run in turn on the shared four-quarter-round unit, then the final
//   add writes the output register once that register is free or being emptied.
//   in_tready is high only while no block is being computed, so the unit
//   takes no new item before the current block has reached the output register.
//   A finished block sits in the output register until taken; the next
//   item is accepted meanwhile, and its finished block waits for the
//   register to free up if the receiver stalls.
//   Reset clears the key, nonce, block counter and output valid.
`timescale 1ns / 1ps

module chacha20_keystream_block_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [cc20_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cc20_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [31:0]                      in_tdata,   // counter_value[31:0]
  input  logic                             in_tuser,   // load_counter
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // words_0_1[63:0], words_2_3, ..., words_14_15[511:448]
  output logic [cc20_pkg::OUT_W-1:0]       out_tdata,
  output logic                             out_tuser   // counter_wrapped
);
  import cc20_pkg::*;

  logic [CFG_W-1:0]  key_r [4];
  logic [CFG_W-1:0]  nonce0_r;
  cc20_word_t        nonce1_r;
  cc20_state_t       init_base;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < 4; p++) begin
        key_r[p] <= '0;
      end
      nonce0_r <= '0;
      nonce1_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_KEY0:   key_r[0] <= cfg_wdata;
        REG_KEY1:   key_r[1] <= cfg_wdata;
        REG_KEY2:   key_r[2] <= cfg_wdata;
        REG_KEY3:   key_r[3] <= cfg_wdata;
        REG_NONCE0: nonce0_r <= cfg_wdata;
        REG_NONCE1: nonce1_r <= cfg_wdata[WORD_W-1:0];
        default: ;
      endcase
    end
  end

  // Input state without the counter word, which the core fills in.
  always_comb begin
    init_base[0] = SIGMA0;
    init_base[1] = SIGMA1;
    init_base[2] = SIGMA2;
    init_base[3] = SIGMA3;
    for (int p = 0; p < 4; p++) begin
      init_base[4 + 2*p] = key_r[p][WORD_W-1:0];
      init_base[5 + 2*p] = key_r[p][CFG_W-1:WORD_W];
    end
    init_base[12] = '0;
    init_base[13] = nonce0_r[WORD_W-1:0];
    init_base[14] = nonce0_r[CFG_W-1:WORD_W];
    init_base[15] = nonce1_r;
  end

  cc20_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .init_base  (init_base),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
